@@ src/pmd_pkg.sv @@
// Package for the dense-graph spanning tree core: codes, widths and sequencer states.
`timescale 1ns / 1ps
`default_nettype none
package pmd_pkg;

  localparam int unsigned VertexWidth = 4;
  localparam int unsigned WeightWidth = 16;
  localparam int unsigned CostWidth   = 20;

  localparam logic [CostWidth-1:0] CostMax = {CostWidth{1'b1}};

  localparam logic OpLoad = 1'b0;
  localparam logic OpRun  = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StScanEnd,
    StCommit,
    StEmitRd,
    StEmitWait,
    StCost
  } state_e;

endpackage
`default_nettype wire

@@ src/prim_mst_dense_core.sv @@
// Top level of the dense-graph minimum spanning tree core (Prim's rule).
`timescale 1ns / 1ps
`default_nettype none
// Load items (opcode 0) write one undirected edge weight into an
// NUM_VERTICES x NUM_VERTICES weight RAM; a load with equal vertices
// or a vertex at or above NUM_VERTICES is dropped. A run item (opcode
// 1) grows a tree from root_vertex (taken as 0 if out of range). Each
// of the NUM_VERTICES-1 growth steps walks every (tree, candidate) pair
// through the single RAM read port and one shared compare unit, and a
// run also waits on any output stall. The run then emits one item per
// non-root vertex in ascending order (child, parent, weight) and a
// final item with the total cost, is_cost and last set. in_ready_o is
// high only between runs. A weight never loaded since reset reads as
// undefined: load every pair before a run. root_vertex is written
// through cfg_we_i/cfg_wdata_i; the user must do so only while idle,
// as the core itself does not enforce it.
module prim_mst_dense_core
  import pmd_pkg::*;
#(
  parameter int unsigned NUM_VERTICES = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration
  input  wire logic                   cfg_we_i,
  input  wire logic [VertexWidth-1:0] cfg_wdata_i,
  // input items
  input  wire logic                   in_valid_i,
  output      logic                   in_ready_o,
  input  wire logic                   opcode_i,
  input  wire logic [VertexWidth-1:0] vertex_a_i,
  input  wire logic [VertexWidth-1:0] vertex_b_i,
  input  wire logic [WeightWidth-1:0] edge_weight_i,
  // result items
  output      logic                   out_valid_o,
  input  wire logic                   out_ready_i,
  output      logic [VertexWidth-1:0] child_vertex_o,
  output      logic [VertexWidth-1:0] parent_vertex_o,
  output      logic [WeightWidth-1:0] tree_edge_weight_o,
  output      logic [CostWidth-1:0]   total_cost_o,
  output      logic                   is_cost_o,
  output      logic                   last_o
);

  localparam int unsigned VW    = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int unsigned Depth = NUM_VERTICES * NUM_VERTICES;
  localparam int unsigned AW    = $clog2(Depth);
  localparam logic [VW-1:0] VLast = VW'(NUM_VERTICES - 1);

  // Edges are stored once, at (smaller vertex, larger vertex).
  function automatic logic [AW-1:0] edge_addr(logic [VW-1:0] a, logic [VW-1:0] b);
    logic [VW-1:0] lo;
    logic [VW-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return AW'(AW'(lo) * AW'(NUM_VERTICES) + AW'(hi));
  endfunction

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  state_e state_q, state_d;

  logic [VertexWidth-1:0] root_q;

  logic [NUM_VERTICES-1:0] in_tree_q, in_tree_d;
  logic [VW-1:0] ptab_q [NUM_VERTICES];
  logic [VW-1:0] ptab_d [NUM_VERTICES];

  logic [VW-1:0] i_q, i_d, j_q, j_d;     // scan pair / emit vertex (j)
  logic [VW-1:0] step_q, step_d;         // vertices added so far

  // compare stage, in the cycle after the RAM address
  logic          p_vld_q, p_vld_d;
  logic [VW-1:0] p_i_q, p_i_d, p_j_q, p_j_d;

  logic                   found_q, found_d;
  logic [WeightWidth-1:0] best_w_q, best_w_d;
  logic [VW-1:0]          best_src_q, best_src_d, best_dst_q, best_dst_d;

  logic [CostWidth-1:0] cost_q, cost_d;

  // output register
  logic                   out_vld_q, out_vld_d;
  logic [VertexWidth-1:0] o_child_q, o_child_d, o_par_q, o_par_d;
  logic [WeightWidth-1:0] o_w_q, o_w_d;
  logic [CostWidth-1:0]   o_cost_q, o_cost_d;
  logic                   o_is_cost_q, o_is_cost_d, o_last_q, o_last_d;

  // weight RAM
  logic [WeightWidth-1:0] mem [Depth];
  logic                   we, re;
  logic [AW-1:0]          waddr, raddr;
  logic [WeightWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= edge_weight_i;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // ---------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------
  logic          root_ok;
  logic [VW-1:0] root_v;
  logic [VW-1:0] va, vb;
  logic          load_ok;
  logic          slot_free;
  logic [CostWidth:0] cost_sum;

  assign root_ok   = (32'(root_q) < NUM_VERTICES);
  assign root_v    = root_ok ? VW'(root_q) : '0;
  assign va        = VW'(vertex_a_i);
  assign vb        = VW'(vertex_b_i);
  assign load_ok   = (vertex_a_i != vertex_b_i) && (32'(vertex_a_i) < NUM_VERTICES)
                     && (32'(vertex_b_i) < NUM_VERTICES);
  assign slot_free = !out_vld_q || out_ready_i;
  assign cost_sum  = {1'b0, cost_q} + (CostWidth+1)'(rdata_q);

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d     = state_q;
    in_tree_d   = in_tree_q;
    ptab_d      = ptab_q;
    i_d         = i_q;
    j_d         = j_q;
    step_d      = step_q;
    p_vld_d     = 1'b0;
    p_i_d       = i_q;
    p_j_d       = j_q;
    found_d     = found_q;
    best_w_d    = best_w_q;
    best_src_d  = best_src_q;
    best_dst_d  = best_dst_q;
    cost_d      = cost_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    o_child_d   = o_child_q;
    o_par_d     = o_par_q;
    o_w_d       = o_w_q;
    o_cost_d    = o_cost_q;
    o_is_cost_d = o_is_cost_q;
    o_last_d    = o_last_q;
    we          = 1'b0;
    waddr       = edge_addr(va, vb);
    re          = 1'b0;
    raddr       = edge_addr(i_q, j_q);

    // shared compare unit: candidate edge from tree vertex to outside
    if (p_vld_q && in_tree_q[p_i_q] && !in_tree_q[p_j_q]) begin
      if (!found_q || (rdata_q < best_w_q)) begin
        found_d    = 1'b1;
        best_w_d   = rdata_q;
        best_src_d = p_i_q;
        best_dst_d = p_j_q;
      end
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (opcode_i == OpLoad) begin
            we = load_ok;
          end else begin
            in_tree_d         = '0;
            in_tree_d[root_v] = 1'b1;
            for (int k = 0; k < NUM_VERTICES; k++) begin
              ptab_d[k] = '0;
            end
            ptab_d[root_v] = root_v;
            i_d     = '0;
            j_d     = '0;
            step_d  = '0;
            found_d = 1'b0;
            cost_d  = '0;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        re      = 1'b1;
        p_vld_d = 1'b1;
        if (j_q == VLast) begin
          j_d = '0;
          if (i_q == VLast) begin
            i_d     = '0;
            state_d = StScanEnd;
          end else begin
            i_d = VW'(i_q + 1'b1);
          end
        end else begin
          j_d = VW'(j_q + 1'b1);
        end
      end
      StScanEnd: begin
        state_d = StCommit;
      end
      StCommit: begin
        in_tree_d[best_dst_q] = 1'b1;
        ptab_d[best_dst_q]    = best_src_q;
        found_d               = 1'b0;
        step_d                = VW'(step_q + 1'b1);
        if (step_q == VW'(NUM_VERTICES - 2)) begin
          j_d     = '0;
          state_d = StEmitRd;
        end else begin
          state_d = StScan;
        end
      end
      StEmitRd: begin
        if (j_q == root_v) begin
          if (j_q == VLast) begin
            state_d = StCost;
          end else begin
            j_d = VW'(j_q + 1'b1);
          end
        end else begin
          re      = 1'b1;
          raddr   = edge_addr(ptab_q[j_q], j_q);
          state_d = StEmitWait;
        end
      end
      StEmitWait: begin
        if (slot_free) begin
          out_vld_d   = 1'b1;
          o_child_d   = VertexWidth'(j_q);
          o_par_d     = VertexWidth'(ptab_q[j_q]);
          o_w_d       = rdata_q;
          o_cost_d    = '0;
          o_is_cost_d = 1'b0;
          o_last_d    = 1'b0;
          cost_d      = cost_sum[CostWidth] ? CostMax : cost_sum[CostWidth-1:0];
          if (j_q == VLast) begin
            state_d = StCost;
          end else begin
            j_d     = VW'(j_q + 1'b1);
            state_d = StEmitRd;
          end
        end
      end
      StCost: begin
        if (slot_free) begin
          out_vld_d   = 1'b1;
          o_child_d   = '0;
          o_par_d     = '0;
          o_w_d       = '0;
          o_cost_d    = cost_q;
          o_is_cost_d = 1'b1;
          o_last_d    = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      root_q    <= '0;
      in_tree_q <= '0;
      for (int k = 0; k < NUM_VERTICES; k++) begin
        ptab_q[k] <= '0;
      end
      i_q       <= '0;
      j_q       <= '0;
      step_q    <= '0;
      p_vld_q   <= 1'b0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
      in_tree_q <= in_tree_d;
      ptab_q    <= ptab_d;
      i_q       <= i_d;
      j_q       <= j_d;
      step_q    <= step_d;
      p_vld_q   <= p_vld_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    p_i_q       <= p_i_d;
    p_j_q       <= p_j_d;
    best_w_q    <= best_w_d;
    best_src_q  <= best_src_d;
    best_dst_q  <= best_dst_d;
    cost_q      <= cost_d;
    o_child_q   <= o_child_d;
    o_par_q     <= o_par_d;
    o_w_q       <= o_w_d;
    o_cost_q    <= o_cost_d;
    o_is_cost_q <= o_is_cost_d;
    o_last_q    <= o_last_d;
  end

  assign out_valid_o        = out_vld_q;
  assign child_vertex_o     = o_child_q;
  assign parent_vertex_o    = o_par_q;
  assign tree_edge_weight_o = o_w_q;
  assign total_cost_o       = o_cost_q;
  assign is_cost_o          = o_is_cost_q;
  assign last_o             = o_last_q;

endmodule
`default_nettype wire
